FILE: src/assert_macros.svh
// assertion macros for the clock core
// clock i_clk and active-low reset i_rst_n must be visible where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define RTTEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset as well
`define RTTEC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/rttec_pkg.sv
// shared types, constants and helpers for the rtc-to-epoch clock core
// no dependencies
`default_nettype none

package rttec_pkg;

    localparam int unsigned RATE_W = 20;
    localparam int unsigned NS_W   = 30;
    localparam int unsigned ITER_W = 7;

    localparam logic [RATE_W-1:0] DEF_RATE     = 20'd100;
    localparam logic [NS_W-1:0]   NS_PER_S     = 30'd1000000000;
    localparam logic [63:0]       SECS_PER_DAY = 64'd86400;
    localparam logic [7:0]        HOUR_MASK    = 8'h7F;
    localparam int unsigned       STB_BIN_BIT  = 2;
    localparam int unsigned       STB_H24_BIT  = 1;
    localparam int unsigned       HOUR_PM_BIT  = 7;
    localparam logic [ITER_W-1:0] ITERS_SEC    = 7'd64;
    localparam logic [ITER_W-1:0] ITERS_NS     = 7'd30;

    typedef struct packed {
        logic        func;
        logic [7:0]  raw_seconds;
        logic [7:0]  raw_minutes;
        logic [7:0]  raw_hours;
        logic [7:0]  raw_day;
        logic [7:0]  raw_month;
        logic [7:0]  raw_year;
        logic [7:0]  raw_century;
        logic [7:0]  status_b;
        logic [63:0] tick_count;
    } t_in_item;

    typedef struct packed {
        logic [63:0]     epoch_seconds;
        logic [NS_W-1:0] nanoseconds;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DEC, ST_CAL, ST_DAYS1, ST_DAYS2, ST_DAYS3, ST_SECS, ST_ANCHOR,
        ST_QSTART, ST_QWAIT, ST_NSSTART, ST_NSWAIT, ST_NSMUL, ST_QSUM, ST_PUSH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CAPTURE, OP_DEC, OP_CAL, OP_DAYS1, OP_DAYS2, OP_DAYS3, OP_SECS,
        OP_ANCHOR, OP_QSTART, OP_QWAIT, OP_NSSTART, OP_NSWAIT, OP_NSMUL, OP_QSUM,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        logic div_busy;
    } t_dp_stat;

    // bcd byte to binary, nibbles above 9 taken as they are
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return {4'd0, v[3:0]} + (hi << 3) + (hi << 1);
    endfunction

endpackage

`default_nettype wire

FILE: src/rttec_div.sv
// restoring divider, one quotient bit per cycle
// uses rttec_pkg
`default_nettype none

module rttec_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [63:0]                  i_dividend,
    input  wire logic [rttec_pkg::RATE_W-1:0] i_divisor,
    input  wire logic [rttec_pkg::ITER_W-1:0] i_iters,
    output      logic [63:0]                  o_quo,
    output      logic [rttec_pkg::RATE_W-1:0] o_rem,
    output      logic                         o_busy
);
    import rttec_pkg::*;

    logic              r_busy;
    logic [ITER_W-1:0] r_cnt;
    logic [63:0]       r_dvd;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_dsr;
    logic [RATE_W:0]   w_rem_sh;
    logic [RATE_W:0]   w_diff;
    logic              w_ge;

    // one shift-subtract step
    always_comb begin
        w_rem_sh = {r_rem, r_dvd[63]};
        w_diff   = w_rem_sh - {1'b0, r_dsr};
        w_ge     = (w_rem_sh >= {1'b0, r_dsr});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_iters;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != ITER_W'(1));
        end
    end

    // datapath, quotient shifts in where dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[62:0], w_ge};
            r_rem <= w_ge ? w_diff[RATE_W-1:0] : w_rem_sh[RATE_W-1:0];
        end
    end

    assign o_quo  = r_dvd;
    assign o_rem  = r_rem;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

FILE: src/rttec_ctrl.sv
// controller state machine for the clock core
// uses rttec_pkg
`default_nettype none

module rttec_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_ready,
    output      logic                o_out_valid,
    input  wire logic                i_out_ready,
    input  wire rttec_pkg::t_dp_stat i_stat,
    output      rttec_pkg::t_dp_cmd  o_cmd
);
    import rttec_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_push;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_push     = (r_state == ST_PUSH) && w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_DEC;
            ST_DEC:     n_state = i_stat.func ? ST_QSTART : ST_CAL;
            ST_CAL:     n_state = ST_DAYS1;
            ST_DAYS1:   n_state = ST_DAYS2;
            ST_DAYS2:   n_state = ST_DAYS3;
            ST_DAYS3:   n_state = ST_SECS;
            ST_SECS:    n_state = ST_ANCHOR;
            ST_ANCHOR:  n_state = ST_PUSH;
            ST_QSTART:  n_state = ST_QWAIT;
            ST_QWAIT:   if (!i_stat.div_busy) n_state = ST_NSSTART;
            ST_NSSTART: n_state = ST_NSWAIT;
            ST_NSWAIT:  if (!i_stat.div_busy) n_state = ST_NSMUL;
            ST_NSMUL:   n_state = ST_QSUM;
            ST_QSUM:    n_state = ST_PUSH;
            ST_PUSH:    if (w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_IDLE:    o_cmd.op = i_in_valid ? OP_CAPTURE : OP_NONE;
            ST_DEC:     o_cmd.op = OP_DEC;
            ST_CAL:     o_cmd.op = OP_CAL;
            ST_DAYS1:   o_cmd.op = OP_DAYS1;
            ST_DAYS2:   o_cmd.op = OP_DAYS2;
            ST_DAYS3:   o_cmd.op = OP_DAYS3;
            ST_SECS:    o_cmd.op = OP_SECS;
            ST_ANCHOR:  o_cmd.op = OP_ANCHOR;
            ST_QSTART:  o_cmd.op = OP_QSTART;
            ST_QWAIT:   o_cmd.op = OP_QWAIT;
            ST_NSSTART: o_cmd.op = OP_NSSTART;
            ST_NSWAIT:  o_cmd.op = OP_NSWAIT;
            ST_NSMUL:   o_cmd.op = OP_NSMUL;
            ST_QSUM:    o_cmd.op = OP_QSUM;
            ST_PUSH:    o_cmd.op = w_out_free ? OP_PUSH : OP_NONE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    // output beat valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_push)
            n_out_valid = 1'b1;
        else if (i_out_ready)
            n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: src/rttec_datapath.sv
// datapath: register decode, day count, tick division and result register
// uses rttec_pkg, rttec_div and rttec_hz_sel
`default_nettype none

module rttec_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rttec_pkg::t_dp_cmd           i_cmd,
    output      rttec_pkg::t_dp_stat          o_stat,
    input  wire rttec_pkg::t_in_item          i_in_data,
    output      rttec_pkg::t_out_item         o_out_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [rttec_pkg::RATE_W-1:0] i_cfg_wdata
);
    import rttec_pkg::*;

    // state and config
    logic [RATE_W-1:0] r_rate;
    logic [63:0]       r_anchor_epoch;
    logic [63:0]       r_anchor_tick;

    // pipeline of the conversion
    t_in_item          r_in;
    logic [7:0]        r_sec, r_min, r_hour, r_day, r_mon, r_year, r_cent;
    logic              r_pm, r_h12;
    logic [11:0]       r_y;
    logic [7:0]        r_mm;
    logic [4:0]        r_q100;
    logic [15:0]       r_t153;
    logic [12:0]       r_doy5;
    logic [19:0]       r_y365;
    logic signed [23:0] r_days;
    logic [63:0]       r_dsec;
    logic [19:0]       r_hms;
    logic [63:0]       r_qsec;
    logic [RATE_W-1:0] r_rem;
    logic [NS_W-1:0]   r_nsq;
    logic [NS_W-1:0]   r_ns;
    logic [63:0]       r_res_epoch;
    logic [NS_W-1:0]   r_res_ns;
    t_out_item         r_out;

    logic              w_h12, w_bcd;
    logic [7:0]        w_hour_raw;
    logic [15:0]       w_hprod;
    logic [4:0]        w_hq;
    logic [7:0]        w_hmod, w_hour_f;
    logic              w_cent_ok, w_early;
    logic [11:0]       w_fyear, w_y;
    logic [7:0]        w_mm;
    logic [23:0]       w_yprod;
    logic [15:0]       w_t153;
    logic [31:0]       w_dprod;
    logic [19:0]       w_y365;
    logic signed [23:0] w_days;
    logic signed [41:0] w_dsx;
    logic [63:0]       w_dsec;
    logic [19:0]       w_hms;
    logic [63:0]       w_epoch;
    logic [63:0]       w_elapsed;
    logic [RATE_W-1:0] w_hz;
    logic [49:0]       w_nsprod;

    logic              w_div_start;
    logic [63:0]       w_div_dvd;
    logic [ITER_W-1:0] w_div_iters;
    logic [63:0]       w_div_quo;
    logic [RATE_W-1:0] w_div_rem;
    logic              w_div_busy;

    // byte decode: pm flag comes off before bcd
    assign w_h12      = ~r_in.status_b[STB_H24_BIT];
    assign w_bcd      = ~r_in.status_b[STB_BIN_BIT];
    assign w_hour_raw = w_h12 ? (r_in.raw_hours & HOUR_MASK) : r_in.raw_hours;

    // hour mod 12 by reciprocal, year and shifted month
    always_comb begin
        w_hprod   = {8'd0, r_hour} * 16'd171;
        w_hq      = w_hprod[15:11];
        w_hmod    = r_hour - {w_hq, 3'b000} - {1'b0, w_hq, 2'b00};
        w_hour_f  = r_h12 ? (w_hmod + (r_pm ? 8'd12 : 8'd0)) : r_hour;
        w_cent_ok = (r_cent >= 8'd19) && (r_cent <= 8'd21);
        w_fyear   = w_cent_ok ? ({4'd0, r_cent} * 12'd100 + {4'd0, r_year})
                              : (12'd2000 + {4'd0, r_year});
        w_early   = (r_mon <= 8'd2);
        w_y       = w_fyear - {11'd0, w_early};
        w_mm      = w_early ? (r_mon + 8'd9) : (r_mon - 8'd3);
    end

    // day count pieces, divisions by constants through reciprocals
    always_comb begin
        w_yprod = {12'd0, r_y} * 24'd5243;
        w_t153  = {8'd0, r_mm} * 16'd153 + 16'd2;
        w_dprod = {16'd0, r_t153} * 32'd52429;
        w_y365  = {8'd0, r_y} * 20'd365;
        w_days  = $signed({4'd0, r_y365}) + $signed({14'd0, r_y[11:2]})
                - $signed({19'd0, r_q100}) + $signed({21'd0, r_q100[4:2]})
                + $signed({11'd0, r_doy5}) + $signed({16'd0, r_day})
                - 24'sd1 - 24'sd719468;
        // signed day count times seconds per day, sign extended to 64 bits
        w_dsx   = r_days * $signed({1'b0, SECS_PER_DAY[16:0]});
        w_dsec  = {{22{w_dsx[41]}}, w_dsx};
        w_hms   = {12'd0, r_hour} * 20'd3600 + {12'd0, r_min} * 20'd60 + {12'd0, r_sec};
        w_epoch = r_dsec + {44'd0, r_hms};
    end

    // query side
    assign w_elapsed = r_in.tick_count - r_anchor_tick;
    assign w_nsprod  = {30'd0, r_rem} * {20'd0, r_nsq};

    rttec_hz_sel u_hz (
        .i_rate (r_rate),
        .o_hz   (w_hz)
    );

    // divider commands
    assign w_div_start = (i_cmd.op == OP_QSTART) || (i_cmd.op == OP_NSSTART);
    assign w_div_dvd   = (i_cmd.op == OP_QSTART) ? w_elapsed : {NS_PER_S, 34'd0};
    assign w_div_iters = (i_cmd.op == OP_QSTART) ? ITERS_SEC : ITERS_NS;

    rttec_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_hz),
        .i_iters    (w_div_iters),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem),
        .o_busy     (w_div_busy)
    );

    // config register and anchor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate         <= DEF_RATE;
            r_anchor_epoch <= '0;
            r_anchor_tick  <= '0;
        end else begin
            if (i_cfg_we)
                r_rate <= i_cfg_wdata;
            if (i_cmd.op == OP_ANCHOR) begin
                r_anchor_epoch <= w_epoch;
                r_anchor_tick  <= r_in.tick_count;
            end
        end
    end

    // working registers, one step per command
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: r_in <= i_in_data;
            OP_DEC: begin
                r_h12  <= w_h12;
                r_pm   <= w_h12 & r_in.raw_hours[HOUR_PM_BIT];
                r_sec  <= w_bcd ? bcd_value(r_in.raw_seconds) : r_in.raw_seconds;
                r_min  <= w_bcd ? bcd_value(r_in.raw_minutes) : r_in.raw_minutes;
                r_hour <= w_bcd ? bcd_value(w_hour_raw) : w_hour_raw;
                r_day  <= w_bcd ? bcd_value(r_in.raw_day) : r_in.raw_day;
                r_mon  <= w_bcd ? bcd_value(r_in.raw_month) : r_in.raw_month;
                r_year <= w_bcd ? bcd_value(r_in.raw_year) : r_in.raw_year;
                r_cent <= w_bcd ? bcd_value(r_in.raw_century) : r_in.raw_century;
            end
            OP_CAL: begin
                r_hour <= w_hour_f;
                r_y    <= w_y;
                r_mm   <= w_mm;
            end
            OP_DAYS1: begin
                r_q100 <= w_yprod[23:19];
                r_t153 <= w_t153;
            end
            OP_DAYS2: begin
                r_doy5 <= w_dprod[30:18];
                r_y365 <= w_y365;
            end
            OP_DAYS3: r_days <= w_days;
            OP_SECS: begin
                r_dsec <= w_dsec;
                r_hms  <= w_hms;
            end
            OP_ANCHOR: begin
                r_res_epoch <= w_epoch;
                r_res_ns    <= '0;
            end
            OP_QWAIT: begin
                if (!w_div_busy) begin
                    r_qsec <= w_div_quo;
                    r_rem  <= w_div_rem;
                end
            end
            OP_NSWAIT: if (!w_div_busy) r_nsq <= w_div_quo[NS_W-1:0];
            OP_NSMUL:  r_ns <= w_nsprod[NS_W-1:0];
            OP_QSUM: begin
                r_res_epoch <= r_anchor_epoch + r_qsec;
                r_res_ns    <= r_ns;
            end
            OP_PUSH: begin
                r_out.epoch_seconds <= r_res_epoch;
                r_out.nanoseconds   <= r_res_ns;
            end
            default: ;
        endcase
    end

    assign o_stat.func     = r_in.func;
    assign o_stat.div_busy = w_div_busy;
    assign o_out_data      = r_out;

endmodule

`default_nettype wire

FILE: src/rttec_top_placeholder.sv
// zero-rate substitution for the tick divider
// uses rttec_pkg
`default_nettype none

module rttec_hz_sel (
    input  wire logic [rttec_pkg::RATE_W-1:0] i_rate,
    output      logic [rttec_pkg::RATE_W-1:0] o_hz
);
    import rttec_pkg::*;

    // a zero rate counts as the default rate
    assign o_hz = (i_rate == '0) ? DEF_RATE : i_rate;

endmodule

`default_nettype wire

FILE: src/rtc_time_to_epoch_clock_core.sv
// Real-time-clock to Unix epoch clock. A latch beat (func 0) decodes the clock
// register bytes (bcd or binary, 12 or 24 hour, per status B) into Unix seconds
// and stores them with the tick count; its result goes through the decode,
// calendar, day-count, seconds and anchor steps, and the next beat can be taken
// once it is pushed to the output register. A query beat (func 1) returns the
// stored epoch plus elapsed ticks divided by the tick rate, and the nanoseconds;
// both divisions run on the shared one-bit-per-cycle divider (64 steps for
// seconds, 30 for the nanosecond scale). One beat is worked on at a time; a new
// beat is taken while a finished result waits in the output register.
// uses rttec_pkg, rttec_ctrl, rttec_datapath, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module rtc_time_to_epoch_clock_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output      logic                         o_in_ready,
    input  wire rttec_pkg::t_in_item          i_in_data,
    output      logic                         o_out_valid,
    input  wire logic                         i_out_ready,
    output      rttec_pkg::t_out_item         o_out_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [rttec_pkg::RATE_W-1:0] i_cfg_wdata
);
    import rttec_pkg::*;

    t_dp_cmd  s_cmd;
    t_dp_stat s_stat;

    // controller
    rttec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (s_stat),
        .o_cmd       (s_cmd)
    );

    // datapath
    rttec_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // checks
    `RTTEC_ASSERT(a_ns_range, o_out_valid |-> (o_out_data.nanoseconds < NS_PER_S), "ns out of range")
    `RTTEC_ASSERT(a_div_blocks_in, s_stat.div_busy |-> !o_in_ready, "accept during division")
    `RTTEC_ASSERT(a_one_at_a_time, (i_in_valid && o_in_ready) |=> !o_in_ready, "second beat taken")
    `RTTEC_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_out_valid, "result after reset")

endmodule

`default_nettype wire
